### hdl/pss_pkg.sv
package pss_pkg;

  localparam int unsigned SINE_ENTRIES    = 256;
  localparam int unsigned DELAY_DEPTH_DEF = 256;
  localparam int unsigned CFG_ADDR_W      = 4;

  // register reset values
  localparam logic [16:0] DAMPING_GAIN_RST    = 17'd65536;
  localparam logic [16:0] ALLPASS_COEFF_RST   = 17'd9175;
  localparam logic [31:0] ERROR_INCREMENT_RST = 32'd429496729;
  localparam logic [8:0]  ENVELOPE_LIMIT_RST  = 9'd400;

  // voice state reset values
  localparam logic [31:0] MAIN_STEP_RST  = 32'd140123308;
  localparam logic [8:0]  LENGTH_RST     = 9'd31;
  localparam logic [7:0]  WRITE_PTR_INIT = 8'd1;
  localparam logic [7:0]  READ_PTR_INIT  = 8'd2;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_PLUCK = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ENV_HOLD = 2'd0,
    ENV_UP   = 2'd1,
    ENV_DOWN = 2'd2
  } env_mode_e;

  typedef enum logic [1:0] {
    REG_DAMPING_GAIN    = 2'd0,
    REG_ALLPASS_COEFF   = 2'd1,
    REG_ERROR_INCREMENT = 2'd2,
    REG_ENVELOPE_LIMIT  = 2'd3
  } reg_e;

  typedef struct packed {
    logic [16:0] damping_gain;
    logic [16:0] allpass_coeff;
    logic [31:0] error_increment;
    logic [8:0]  envelope_limit;
  } cfg_t;

  typedef logic signed [11:0] sine_rom_t [SINE_ENTRIES];

  // trunc(2047 * sin(i * 6.283 / 256)), evaluated at elaboration
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    real       x;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      x      = 2047.0 * $sin(real'(i) * 6.283 / 256.0);
      rom[i] = 12'($rtoi(x));
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // saturate a signed sample into the 12-bit dac range
  function automatic logic [11:0] clamp12(logic signed [15:0] v);
    logic [11:0] r;
    if (v < 16'sd0) begin
      r = 12'd0;
    end else if (v > 16'sd4095) begin
      r = 12'd4095;
    end else begin
      r = v[11:0];
    end
    return r;
  endfunction

endpackage

### hdl/pss_if.sv
interface pss_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [7:0]         entry_index;
  logic signed [31:0] entry_value;
  logic [8:0]         string_length;
  logic [31:0]        pitch_increment;
  logic [1:0]         envelope_mode;
  logic               advance;
  logic               error_tone;

  modport source (
    output valid, command, entry_index, entry_value, string_length,
           pitch_increment, envelope_mode, advance, error_tone,
    input  ready
  );
  modport sink (
    input  valid, command, entry_index, entry_value, string_length,
           pitch_increment, envelope_mode, advance, error_tone,
    output ready
  );
endinterface

interface pss_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] tone_sample;
  logic [11:0] string_sample;

  modport source (
    output valid, tone_sample, string_sample,
    input  ready
  );
  modport sink (
    input  valid, tone_sample, string_sample,
    output ready
  );
endinterface

### hdl/pss_cfg_regs.sv
module pss_cfg_regs
  import pss_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_e'(paddr[3:2]))
        REG_DAMPING_GAIN:    cfg_d.damping_gain    = pwdata[16:0];
        REG_ALLPASS_COEFF:   cfg_d.allpass_coeff   = pwdata[16:0];
        REG_ERROR_INCREMENT: cfg_d.error_increment = pwdata;
        REG_ENVELOPE_LIMIT:  cfg_d.envelope_limit  = pwdata[8:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.damping_gain    <= DAMPING_GAIN_RST;
      cfg_q.allpass_coeff   <= ALLPASS_COEFF_RST;
      cfg_q.error_increment <= ERROR_INCREMENT_RST;
      cfg_q.envelope_limit  <= ENVELOPE_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_e'(paddr[3:2]))
      REG_DAMPING_GAIN:    prdata = 32'(cfg_q.damping_gain);
      REG_ALLPASS_COEFF:   prdata = 32'(cfg_q.allpass_coeff);
      REG_ERROR_INCREMENT: prdata = cfg_q.error_increment;
      REG_ENVELOPE_LIMIT:  prdata = 32'(cfg_q.envelope_limit);
      default:             prdata = '0;
    endcase
  end

endmodule

### hdl/plucked_string_and_tone_synth.sv
// Two-voice audio synth, one output transaction per sample tick. Channel A carries an
// enveloped sine tone offset to 2048; channel B carries a Karplus-Strong plucked string
// (two taps of a Q16.16 delay line, averaged, damped and all-pass tuned, clamped to
// 0..4095) or, with error_tone set, a small error tone. A load transaction writes one
// delay-line entry, a pluck transaction sets string length and pitch and restarts the
// string; neither produces an output, and both leave the block ready. A tick keeps
// the block busy through RDB, AVG, DAMP, DIFF, AP and WB before it is ready: the delay
// memory has one read port, so the two taps are read one after the other, and the
// loop filter runs its damping and all-pass multiplies in separate registered steps
// before the write-back. The result sits in an output register, so the next
// transaction is taken while it waits; a later tick only holds at write-back while
// that register is still full. The delay memory needs no clearing pass after reset:
// it must be loaded before the string is played. Registers live on an APB port at
// byte addresses 0, 4, 8 and 12 (damping gain, all-pass coefficient, error tone step,
// envelope limit); the user must write them only while idle; the block does not check.
module plucked_string_and_tone_synth
  import pss_pkg::*;
#(
  parameter int unsigned DELAY_DEPTH = DELAY_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pss_in_if.sink                item_i,
  pss_out_if.source             result_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned AW      = $clog2(DELAY_DEPTH);
  localparam int unsigned LEN_MAX = (DELAY_DEPTH < 256) ? DELAY_DEPTH : 256;

  // tick sequencer
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RDB  = 3'd1;
  localparam logic [2:0] ST_AVG  = 3'd2;
  localparam logic [2:0] ST_DAMP = 3'd3;
  localparam logic [2:0] ST_DIFF = 3'd4;
  localparam logic [2:0] ST_AP   = 3'd5;
  localparam logic [2:0] ST_WB   = 3'd6;

  cfg_t cfg;

  pss_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // pointer to memory address, pointers can run past a small memory before a pluck
  function automatic logic [AW-1:0] ptr_addr(logic [7:0] p);
    logic [12:0] w;
    w = 13'(p);
    if (w >= 13'(DELAY_DEPTH)) begin
      w = w - 13'(DELAY_DEPTH);
    end
    return AW'(w);
  endfunction

  // (p + 1) mod len, p never reaches 2*len
  function automatic logic [7:0] step_ptr(logic [7:0] p, logic [8:0] len);
    logic [8:0] n;
    n = {1'b0, p} + 9'd1;
    if (n >= len) begin
      n = n - len;
    end
    return n[7:0];
  endfunction

  function automatic logic [8:0] clamp_len(logic [8:0] l);
    logic [8:0] r;
    if (l < 9'd2) begin
      r = 9'd2;
    end else if (l > 9'(LEN_MAX)) begin
      r = 9'(LEN_MAX);
    end else begin
      r = l;
    end
    return r;
  endfunction

  // control state
  logic [2:0]         state_q, state_d;
  logic [7:0]         wp_q, wp_d, rp_q, rp_d;
  logic [8:0]         len_q, len_d;
  logic [31:0]        main_phase_q, main_phase_d;
  logic [31:0]        err_phase_q, err_phase_d;
  logic [31:0]        main_step_q, main_step_d;
  logic [8:0]         env_q, env_d;
  logic signed [31:0] last_out_q, last_out_d;
  logic signed [31:0] last_in_q, last_in_d;
  logic               out_valid_q, out_valid_d;

  // datapath registers
  logic               adv_q, err_sel_q;
  logic signed [31:0] a_q, avg_q, damped_q, diff_q, ap_q;
  logic signed [21:0] tprod_q;
  logic signed [11:0] err_sine_q;
  logic [11:0]        tone_q, string_q;

  // delay memory
  logic signed [31:0] delay_mem [DELAY_DEPTH];
  logic signed [31:0] mem_rdata_q;
  logic [AW-1:0]      mem_raddr, mem_waddr;
  logic signed [31:0] mem_wdata;
  logic               mem_we;

  logic               in_acc, wb_fire;
  logic signed [32:0] tap_sum;
  logic signed [49:0] damp_prod, ap_prod;
  logic signed [31:0] nxt;
  logic signed [12:0] tone_sum;
  logic [11:0]        str_sample;

  assign item_i.ready = (state_q == ST_IDLE);
  assign in_acc       = item_i.valid && item_i.ready;

  assign result_o.valid         = out_valid_q;
  assign result_o.tone_sample   = tone_q;
  assign result_o.string_sample = string_q;

  // loop filter arithmetic: the tap sum keeps its carry, the rest wraps at 32 bits
  assign tap_sum   = {a_q[31], a_q} + {mem_rdata_q[31], mem_rdata_q};
  assign damp_prod = $signed({1'b0, cfg.damping_gain}) * avg_q;
  assign ap_prod   = $signed({1'b0, cfg.allpass_coeff}) * diff_q;
  assign nxt       = ap_q + last_in_q;

  // tone always stays inside 0..4095, the envelope bounds the product
  assign tone_sum = {{3{tprod_q[21]}}, tprod_q[21:12]} + 13'sd2048;

  assign str_sample = err_sel_q ? clamp12({{12{err_sine_q[11]}}, err_sine_q[11:8]})
                                : clamp12(a_q[31:16]);

  // first tap at the write pointer in the accept cycle, second at the read pointer
  assign mem_raddr = (state_q == ST_IDLE) ? ptr_addr(wp_q) : ptr_addr(rp_q);

  always_comb begin
    state_d      = state_q;
    wp_d         = wp_q;
    rp_d         = rp_q;
    len_d        = len_q;
    main_phase_d = main_phase_q;
    err_phase_d  = err_phase_q;
    main_step_d  = main_step_q;
    env_d        = env_q;
    last_out_d   = last_out_q;
    last_in_d    = last_in_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    wb_fire      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd_e'(item_i.command))
            CMD_TICK: begin
              err_phase_d  = err_phase_q + cfg.error_increment;
              main_phase_d = main_phase_q + main_step_q;
              case (env_mode_e'(item_i.envelope_mode))
                ENV_HOLD: ;
                ENV_UP: begin
                  // a lowered limit below the level just holds it
                  if (env_q < cfg.envelope_limit) begin
                    env_d = env_q + 9'd1;
                  end
                end
                ENV_DOWN: begin
                  if (env_q != 9'd0) begin
                    env_d = env_q - 9'd1;
                  end
                end
                default: ;
              endcase
              state_d = ST_RDB;
            end
            CMD_LOAD: begin
              // indices past the end of the memory are dropped
              if (32'(item_i.entry_index) < DELAY_DEPTH) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(item_i.entry_index);
                mem_wdata = item_i.entry_value;
              end
            end
            CMD_PLUCK: begin
              len_d       = clamp_len(item_i.string_length);
              main_step_d = item_i.pitch_increment;
              wp_d        = WRITE_PTR_INIT;
              rp_d        = READ_PTR_INIT;
              last_out_d  = '0;
              last_in_d   = '0;
            end
            default: ;
          endcase
        end
      end
      ST_RDB:  state_d = ST_AVG;
      ST_AVG:  state_d = ST_DAMP;
      ST_DAMP: state_d = ST_DIFF;
      ST_DIFF: state_d = ST_AP;
      ST_AP:   state_d = ST_WB;
      ST_WB: begin
        // hold here while the previous sample is still unclaimed
        if (!out_valid_q || result_o.ready) begin
          wb_fire    = 1'b1;
          mem_we     = 1'b1;
          mem_waddr  = ptr_addr(wp_q);
          mem_wdata  = nxt;
          last_out_d = nxt;
          last_in_d  = damped_q;
          if (adv_q) begin
            wp_d = step_ptr(wp_q, len_q);
            rp_d = step_ptr(rp_q, len_q);
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (wb_fire) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      wp_q         <= WRITE_PTR_INIT;
      rp_q         <= READ_PTR_INIT;
      len_q        <= LENGTH_RST;
      main_phase_q <= '0;
      err_phase_q  <= '0;
      main_step_q  <= MAIN_STEP_RST;
      env_q        <= '0;
      last_out_q   <= '0;
      last_in_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      wp_q         <= wp_d;
      rp_q         <= rp_d;
      len_q        <= len_d;
      main_phase_q <= main_phase_d;
      err_phase_q  <= err_phase_d;
      main_step_q  <= main_step_d;
      env_q        <= env_d;
      last_out_q   <= last_out_d;
      last_in_q    <= last_in_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          adv_q     <= item_i.advance;
          err_sel_q <= item_i.error_tone;
        end
      end
      ST_RDB: begin
        a_q        <= mem_rdata_q;
        tprod_q    <= SINE_ROM[main_phase_q[31:24]] * $signed({1'b0, env_q});
        err_sine_q <= SINE_ROM[err_phase_q[31:24]];
      end
      ST_AVG:  avg_q    <= tap_sum[32:1];
      ST_DAMP: damped_q <= damp_prod[47:16];
      ST_DIFF: diff_q   <= damped_q - last_out_q;
      ST_AP:   ap_q     <= ap_prod[47:16];
      ST_WB: begin
        if (wb_fire) begin
          tone_q   <= tone_sum[11:0];
          string_q <= str_sample;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      delay_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= delay_mem[mem_raddr];
  end

`ifndef SYNTHESIS
  // write pointer stays inside the active length, read pointer at most on its end
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, wp_q} < len_q) && ({1'b0, rp_q} <= len_q))
    else $error("string pointer outside active length");

  // pluck restarts the string with a legal length
  a_pluck: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && item_i.command == CMD_PLUCK) |=>
      (len_q >= 9'd2 && len_q <= 9'(LEN_MAX) &&
       wp_q == WRITE_PTR_INIT && rp_q == READ_PTR_INIT &&
       last_out_q == '0 && last_in_q == '0))
    else $error("pluck did not restart the string");

  // every write-back hands a sample to the output register
  a_wb_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_fire |=> (result_o.valid && state_q == ST_IDLE))
    else $error("write-back without output sample");

  // envelope only climbs up to the limit in force
  a_env: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (env_q > $past(env_q)) |-> (env_q <= $past(cfg.envelope_limit)))
    else $error("envelope ramp passed its limit");
`endif

endmodule

### tb/sv/plucked_string_and_tone_synth_test.sv
`timescale 1ns / 1ps

module plucked_string_and_tone_synth_test;
  import pss_pkg::*;

  // run limits, gap rates and the long receiver hold-off
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 24;     // room for the last tick to run through to its write-back
  localparam int STALL_CYCLES  = 300;
  localparam int GAP_PERCENT   = 28;
  localparam int PHASE_ITEMS   = 50;
  localparam int LEN_MAX       = (DELAY_DEPTH_DEF < 256) ? DELAY_DEPTH_DEF : 256;

  // codes the package leaves unnamed: the block must ignore or hold on these
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam logic [1:0] ENV_SPARE = 2'd3;

  // pi and pi/2 in unsigned q4.60, for the fixed-point sine table
  localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;

  // one synth command as it goes over the input channel
  typedef struct {
    logic [1:0]  command;
    logic [7:0]  index;
    logic [31:0] value;
    logic [8:0]  length;
    logic [31:0] pitch;
    logic [1:0]  mode;
    logic        adv;
    logic        err;
  } synth_cmd_t;

  // one dac sample pair, channel a and channel b
  typedef struct {
    logic [11:0] tone;
    logic [11:0] pluck;
  } dac_pair_t;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  pss_in_if  item_if ();
  pss_out_if res_if ();

  plucked_string_and_tone_synth uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (res_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #2 clk_i = ~clk_i;

  // commands waiting to be driven, and the dac samples the voices should produce
  synth_cmd_t command_fifo [$];
  dac_pair_t  sample_fifo [$];
  synth_cmd_t on_wire;
  logic       item_taken = 1'b0;

  int  cycle_cnt  = 0;
  int  mismatches = 0;
  bit  no_gaps    = 1'b0;
  bit  hold_req   = 1'b0;
  int  hold_left  = 0;

  // ---------------------------------------------------------------------------
  // voice model: sine table, delay line, all-pass tuner, phases and envelope
  // ---------------------------------------------------------------------------
  int          sine_tab [SINE_ENTRIES];
  int          delay_mem [DELAY_DEPTH_DEF];
  int          wr_ptr, rd_ptr, str_len;
  int          ap_out, ap_in;
  logic [31:0] main_ph, err_ph, main_inc;
  logic [8:0]  env_lvl;
  cfg_t        cfg;

  // bits 123:60 of the full product, i.e. a q4.60 multiply that drops the top nibble
  function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // trunc(2047*sin(i*6.283/256)) from a taylor series in q4.60
  function automatic int sine_point(int unsigned i);
    logic [63:0] q, x, x2, term, sum, v;
    logic        neg;
    q   = 64'(i) * 64'd6283;
    x   = q * 64'd4503599627370 + (q * 64'd496) / 64'd1000;
    neg = 1'b0;
    if (x >= PI_Q60) begin
      x   = x - PI_Q60;
      neg = 1'b1;
    end
    if (x > HALF_PI_Q60) x = PI_Q60 - x;
    x2   = mul_q60(x, x);
    term = x;
    sum  = x;
    for (int k = 1; k <= 15; k++) begin
      term = mul_q60(term, x2) / (64'(2 * k) * 64'(2 * k + 1));
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    v = ({32'd0, sum[63:32]} * 64'd2047 + (({32'd0, sum[31:0]} * 64'd2047) >> 32)) >> 28;
    return neg ? -int'(v) : int'(v);
  endfunction

  function automatic int clamp_length(logic [8:0] len);
    if (len < 2) return 2;
    if (len > LEN_MAX) return LEN_MAX;
    return int'(len);
  endfunction

  function automatic logic [11:0] dac_clamp(longint v);
    if (v < 0) return 12'd0;
    if (v > 4095) return 12'd4095;
    return 12'(v);
  endfunction

  // pointer step modulo the active string length
  function automatic int next_tap(int p);
    int n;
    n = p + 1;
    while (n >= str_len) n -= str_len;
    return n;
  endfunction

  // apply one accepted command to the voice model, queueing the sample a tick produces
  task automatic play_command(synth_cmd_t c);
    dac_pair_t s;
    longint    a, b, avg, strv, tone;
    int        damped, diff, nxt;
    case (c.command)
      CMD_LOAD: delay_mem[c.index] = c.value;
      CMD_PLUCK: begin
        str_len  = clamp_length(c.length);
        main_inc = c.pitch;
        wr_ptr   = WRITE_PTR_INIT;
        rd_ptr   = READ_PTR_INIT;
        ap_out   = 0;
        ap_in    = 0;
      end
      CMD_TICK: begin
        err_ph  = err_ph + cfg.error_increment;
        main_ph = main_ph + main_inc;
        if (c.mode == ENV_UP) begin
          if (env_lvl < cfg.envelope_limit) env_lvl++;
        end else if (c.mode == ENV_DOWN) begin
          if (env_lvl != 0) env_lvl--;
        end
        tone = ((longint'(sine_tab[main_ph[31:24]]) * longint'(env_lvl)) >>> 12) + 2048;

        // karplus-strong loop: average two taps, damp, all-pass tune, write back
        a      = delay_mem[wr_ptr];
        b      = delay_mem[rd_ptr];
        strv   = a >>> 16;
        avg    = (a + b) >>> 1;
        damped = int'((longint'(cfg.damping_gain) * avg) >>> 16);
        diff   = damped - ap_out;
        nxt    = int'((longint'(cfg.allpass_coeff) * longint'(diff)) >>> 16) + ap_in;
        delay_mem[wr_ptr] = nxt;
        ap_out = nxt;
        ap_in  = damped;

        if (c.adv) begin
          wr_ptr = next_tap(wr_ptr);
          rd_ptr = next_tap(rd_ptr);
        end
        if (c.err) strv = longint'(sine_tab[err_ph[31:24]]) >>> 8;

        s.tone  = dac_clamp(tone);
        s.pluck = dac_clamp(strv);
        sample_fifo.push_back(s);
      end
      default: ;
    endcase
  endtask

  task automatic report(string msg);
    $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus side: which delay entries hold data, so no tick reads an empty one
  // ---------------------------------------------------------------------------
  bit loaded [DELAY_DEPTH_DEF];
  int gen_len = LENGTH_RST;

  // every field but the command random; callers overwrite the ones that matter
  function automatic synth_cmd_t random_cmd();
    synth_cmd_t c;
    c.command = CMD_TICK;
    c.index   = 8'($urandom());
    c.value   = $urandom();
    c.length  = 9'($urandom());
    c.pitch   = $urandom();
    c.mode    = 2'($urandom());
    c.adv     = 1'($urandom());
    c.err     = 1'($urandom());
    return c;
  endfunction

  // the taps stay within 0..max(length,3)-1, since the pointers start at 1 and 2
  function automatic bit string_ready();
    int top;
    top = (gen_len < 3) ? 3 : gen_len;
    for (int i = 0; i < top; i++) if (!loaded[i]) return 1'b0;
    return 1'b1;
  endfunction

  // excitation noise, mostly the usual 0..4095 scaled up, sometimes negative or raw
  function automatic logic [31:0] noise_word();
    int r;
    r = $urandom_range(99);
    if (r < 70) return {4'd0, 12'($urandom_range(4095)), 16'd0};
    if (r < 80) return -{4'd0, 12'($urandom_range(4095)), 16'd0};
    return $urandom();
  endfunction

  task automatic put_load(int idx, logic [31:0] val);
    synth_cmd_t c;
    c         = random_cmd();
    c.command = CMD_LOAD;
    c.index   = 8'(idx);
    c.value   = val;
    loaded[idx] = 1'b1;
    command_fifo.push_back(c);
  endtask

  task automatic put_pluck(logic [8:0] len, logic [31:0] pitch);
    synth_cmd_t c;
    c         = random_cmd();
    c.command = CMD_PLUCK;
    c.length  = len;
    c.pitch   = pitch;
    gen_len   = clamp_length(len);
    command_fifo.push_back(c);
  endtask

  task automatic put_tick(logic [1:0] mode, logic adv, logic err);
    synth_cmd_t c;
    c         = random_cmd();
    c.command = CMD_TICK;
    c.mode    = mode;
    c.adv     = adv;
    c.err     = err;
    command_fifo.push_back(c);
  endtask

  task automatic put_spare();
    synth_cmd_t c;
    c         = random_cmd();
    c.command = CMD_SPARE;
    command_fifo.push_back(c);
  endtask

  // a well-formed note: pluck, fresh noise over the whole string, then a run of ticks
  task automatic pluck_sequence(logic [8:0] len, int nticks, output int made);
    int         span;
    logic [1:0] fav;
    put_pluck(len, $urandom());
    span = (gen_len < 3) ? 3 : gen_len;
    for (int i = 0; i < span; i++) put_load(i, noise_word());
    fav = 2'($urandom_range(3));
    repeat (nticks) begin
      put_tick(($urandom_range(99) < 70) ? fav : 2'($urandom_range(3)),
               $urandom_range(99) < 85, $urandom_range(99) < 12);
    end
    made = span + 1 + nticks;
  endtask

  // mostly notes with random content, the rest stray loads, plucks, ticks and unused codes
  task automatic run_phase(int budget);
    int         made, got, lr;
    logic [8:0] len;
    made = 0;
    while (made < budget) begin
      if ($urandom_range(99) < 72) begin
        lr = $urandom_range(99);
        if (lr < 3) len = 9'($urandom_range(511, 256));
        else if (lr < 10) len = 9'($urandom_range(1));
        else len = 9'($urandom_range(20, 2));
        pluck_sequence(len, $urandom_range(40, 4), got);
        made += got;
      end else begin
        case ($urandom_range(3))
          0: begin
            put_load($urandom_range(255), noise_word());
            made++;
          end
          1: begin
            put_pluck(9'($urandom_range(511)), $urandom());
            made++;
          end
          2: put_spare();
          default: begin
            if (string_ready()) begin
              put_tick(2'($urandom_range(3)), 1'($urandom()), 1'($urandom()));
              made++;
            end
          end
        endcase
      end
    end
  endtask

  // wait until every command is taken and every sample is back, then let the pipe empty
  task automatic drain();
    while (command_fifo.size() != 0 || item_if.valid || sample_fifo.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // apb write followed by a readback of the same register
  task automatic set_reg(reg_e r, logic [31:0] v);
    logic [31:0] want;
    case (r)
      REG_DAMPING_GAIN: begin
        cfg.damping_gain = v[16:0];
        want = {15'd0, v[16:0]};
      end
      REG_ALLPASS_COEFF: begin
        cfg.allpass_coeff = v[16:0];
        want = {15'd0, v[16:0]};
      end
      REG_ERROR_INCREMENT: begin
        cfg.error_increment = v;
        want = v;
      end
      default: begin
        cfg.envelope_limit = v[8:0];
        want = {23'd0, v[8:0]};
      end
    endcase
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    // register takes the value at the next rising edge, then a read setup follows
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want)
      report($sformatf("register %s reads %h, expected %h", r.name(), prdata, want));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // input driver: new transaction at the falling edge once the last one was taken
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && (!item_if.valid || item_taken)) begin
      item_taken = 1'b0;
      if (command_fifo.size() != 0 && (no_gaps || $urandom_range(99) >= GAP_PERCENT)) begin
        on_wire = command_fifo.pop_front();
        item_if.valid           <= 1'b1;
        item_if.command         <= on_wire.command;
        item_if.entry_index     <= on_wire.index;
        item_if.entry_value     <= on_wire.value;
        item_if.string_length   <= on_wire.length;
        item_if.pitch_increment <= on_wire.pitch;
        item_if.envelope_mode   <= on_wire.mode;
        item_if.advance         <= on_wire.adv;
        item_if.error_tone      <= on_wire.err;
      end else begin
        item_if.valid <= 1'b0;
      end
    end
  end

  // an input transaction completes here; the voice model advances with it
  always @(posedge clk_i) begin
    if (rst_ni && item_if.valid && item_if.ready) begin
      play_command(on_wire);
      item_taken = 1'b1;
    end
  end

  // result receiver: random back-pressure, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = STALL_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= no_gaps || ($urandom_range(99) >= GAP_PERCENT);
    end
  end

  // result monitor: each output transaction against the oldest predicted sample
  always @(posedge clk_i) begin
    dac_pair_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (sample_fifo.size() == 0) begin
        report($sformatf("unexpected result tone %0d string %0d",
                         res_if.tone_sample, res_if.string_sample));
      end else begin
        want = sample_fifo.pop_front();
        if (res_if.tone_sample !== want.tone)
          report($sformatf("tone_sample %0d, expected %0d", res_if.tone_sample, want.tone));
        if (res_if.string_sample !== want.pluck)
          report($sformatf("string_sample %0d, expected %0d", res_if.string_sample, want.pluck));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int got;
    item_if.valid           = 1'b0;
    item_if.command         = CMD_TICK;
    item_if.entry_index     = '0;
    item_if.entry_value     = '0;
    item_if.string_length   = '0;
    item_if.pitch_increment = '0;
    item_if.envelope_mode   = ENV_HOLD;
    item_if.advance         = 1'b0;
    item_if.error_tone      = 1'b0;
    res_if.ready            = 1'b0;

    // model state after reset
    for (int i = 0; i < SINE_ENTRIES; i++) sine_tab[i] = sine_point(i);
    for (int i = 0; i < DELAY_DEPTH_DEF; i++) delay_mem[i] = 0;
    cfg.damping_gain    = DAMPING_GAIN_RST;
    cfg.allpass_coeff   = ALLPASS_COEFF_RST;
    cfg.error_increment = ERROR_INCREMENT_RST;
    cfg.envelope_limit  = ENVELOPE_LIMIT_RST;
    wr_ptr   = WRITE_PTR_INIT;
    rd_ptr   = READ_PTR_INIT;
    str_len  = LENGTH_RST;
    ap_out   = 0;
    ap_in    = 0;
    main_ph  = '0;
    err_ph   = '0;
    main_inc = MAIN_STEP_RST;
    env_lvl  = '0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: entry extremes, length clamps at the low end, every envelope mode,
    // envelope floor, pointer advance, error tone and the unused command
    put_load(255, 32'hFFFF_FFFF);
    put_load(0, 32'h7FFF_FFFF);
    put_load(1, 32'h8000_0000);
    put_load(2, 32'h0FFF_0000);
    put_pluck(9'd0, 32'hFFFF_FFFF);
    put_tick(ENV_UP, 1'b0, 1'b0);
    put_tick(ENV_UP, 1'b1, 1'b0);
    put_tick(ENV_UP, 1'b1, 1'b1);
    put_tick(ENV_DOWN, 1'b1, 1'b0);
    put_tick(ENV_DOWN, 1'b1, 1'b0);
    put_tick(ENV_DOWN, 1'b0, 1'b0);
    put_tick(ENV_DOWN, 1'b1, 1'b0);
    put_tick(ENV_SPARE, 1'b1, 1'b1);
    put_tick(ENV_HOLD, 1'b1, 1'b1);
    put_spare();
    put_load(3, 32'h0001_0000);
    put_pluck(9'd1, 32'h0000_0000);
    put_tick(ENV_HOLD, 1'b1, 1'b0);
    put_pluck(9'd3, 32'h1234_5678);
    put_tick(ENV_UP, 1'b1, 1'b1);
    put_tick(ENV_UP, 1'b1, 1'b0);
    put_tick(ENV_UP, 1'b1, 1'b1);
    drain();

    // unity damping gain, no all-pass, silent error tone, widest envelope; a full-length string
    set_reg(REG_DAMPING_GAIN, 32'd65536);
    set_reg(REG_ALLPASS_COEFF, 32'd0);
    set_reg(REG_ERROR_INCREMENT, 32'd0);
    set_reg(REG_ENVELOPE_LIMIT, 32'd511);
    pluck_sequence(9'd511, 30, got);
    run_phase(PHASE_ITEMS);
    drain();

    // opposite extremes, limit lowered under the current level; no gaps on either side
    set_reg(REG_DAMPING_GAIN, 32'd0);
    set_reg(REG_ALLPASS_COEFF, 32'd65536);
    set_reg(REG_ERROR_INCREMENT, 32'hFFFF_FFFF);
    set_reg(REG_ENVELOPE_LIMIT, 32'd3);
    no_gaps = 1'b1;
    run_phase(PHASE_ITEMS);
    drain();
    no_gaps = 1'b0;

    // random settings while the receiver holds off long enough to back up the input
    set_reg(REG_DAMPING_GAIN, $urandom_range(65536));
    set_reg(REG_ALLPASS_COEFF, $urandom_range(65536));
    set_reg(REG_ERROR_INCREMENT, $urandom());
    set_reg(REG_ENVELOPE_LIMIT, $urandom_range(511));
    hold_req = 1'b1;
    run_phase(PHASE_ITEMS);
    drain();

    // reset-like tuning with a zero envelope limit
    set_reg(REG_DAMPING_GAIN, $urandom_range(65536));
    set_reg(REG_ALLPASS_COEFF, ALLPASS_COEFF_RST);
    set_reg(REG_ERROR_INCREMENT, ERROR_INCREMENT_RST);
    set_reg(REG_ENVELOPE_LIMIT, 32'd0);
    run_phase(PHASE_ITEMS);
    drain();

    // light damping with some tuning, moderate envelope
    set_reg(REG_DAMPING_GAIN, $urandom_range(65536, 60000));
    set_reg(REG_ALLPASS_COEFF, $urandom_range(20000));
    set_reg(REG_ERROR_INCREMENT, $urandom());
    set_reg(REG_ENVELOPE_LIMIT, $urandom_range(40, 8));
    run_phase(PHASE_ITEMS);
    drain();

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
hdl/pss_pkg.sv
hdl/pss_if.sv
hdl/pss_cfg_regs.sv
hdl/plucked_string_and_tone_synth.sv
tb/sv/plucked_string_and_tone_synth_test.sv
